// ===== hdl/cms_pkg.sv =====
`timescale 1ns / 1ps

package cms_pkg;

	localparam int FRAME_BYTES = 7;
	localparam int FILL_W      = 3;
	localparam int LEN_W       = 4;
	localparam int SEG_IDX_W   = 6;

	typedef enum logic [1:0] {
		SEG_SINGLE = 2'd0,
		SEG_BEGIN  = 2'd1,
		SEG_MIDDLE = 2'd2,
		SEG_END    = 2'd3
	} seg_type_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [28:0] frame_id;
	} byte_item_t;

	typedef struct packed {
		logic [28:0]          out_id;
		logic [1:0]           segment_type;
		logic [SEG_IDX_W-1:0] segment_index;
		logic [LEN_W-1:0]     length_code;
		logic [7:0]           payload_0;
		logic [7:0]           payload_1;
		logic [7:0]           payload_2;
		logic [7:0]           payload_3;
		logic [7:0]           payload_4;
		logic [7:0]           payload_5;
		logic [7:0]           payload_6;
	} frame_item_t;

endpackage

// ===== hdl/cms_packer.sv =====
`timescale 1ns / 1ps

module cms_packer #(
	parameter int INDEX_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  cms_pkg::byte_item_t  item,
	output logic                 emit,
	output cms_pkg::frame_item_t frame
);
	import cms_pkg::*;

	logic [7:0]            store_q [FRAME_BYTES];
	logic [FILL_W-1:0]     fill_q;
	logic [INDEX_BITS-1:0] seg_cnt_q;
	logic                  first_q;
	logic [7:0]            bytes [FRAME_BYTES];
	seg_type_t             seg_type;

	always_comb begin
		for (int k = 0; k < FRAME_BYTES; k++) begin
			if (FILL_W'(k) < fill_q) begin
				bytes[k] = store_q[k];
			end else if (FILL_W'(k) == fill_q) begin
				bytes[k] = item.data_byte;
			end else begin
				bytes[k] = 8'd0;
			end
		end
	end

	assign emit = item.last_byte || (fill_q == FILL_W'(FRAME_BYTES - 1));

	always_comb begin
		if (item.last_byte) begin
			seg_type = first_q ? SEG_SINGLE : SEG_END;
		end else begin
			seg_type = first_q ? SEG_BEGIN : SEG_MIDDLE;
		end
	end

	always_comb begin
		frame.out_id        = item.frame_id;
		frame.segment_type  = seg_type;
		frame.segment_index = first_q ? '0 : SEG_IDX_W'(seg_cnt_q);
		frame.length_code   = LEN_W'(fill_q) + LEN_W'(2);
		frame.payload_0     = bytes[0];
		frame.payload_1     = bytes[1];
		frame.payload_2     = bytes[2];
		frame.payload_3     = bytes[3];
		frame.payload_4     = bytes[4];
		frame.payload_5     = bytes[5];
		frame.payload_6     = bytes[6];
	end

	always_ff @(posedge clk) begin
		if (step && !emit) begin
			store_q[fill_q] <= item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			seg_cnt_q <= '0;
			first_q   <= 1'b1;
		end else if (step) begin
			if (!emit) begin
				fill_q <= fill_q + FILL_W'(1);
			end else begin
				fill_q <= '0;
				if (item.last_byte) begin
					seg_cnt_q <= '0;
					first_q   <= 1'b1;
				end else begin
					seg_cnt_q <= seg_cnt_q + INDEX_BITS'(1);
					first_q   <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== hdl/can_message_segmenter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Item
// data      in         data_valid / data_stall   one payload byte, last mark, identifier
// frame     out        frame_valid / frame_stall one CAN data frame
//
// One item is accepted per cycle while data_stall is low; a byte passes through
// the input register and the packer logic to the frame register.
// Reset clears the byte count, segment counter and both valid flags.
// A stalled frame holds the input register only when the waiting byte would
// produce another frame; bytes that complete no frame keep flowing.

module can_message_segmenter #(
	parameter int INDEX_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_stall,
	input  cms_pkg::byte_item_t  data,
	output logic                 frame_valid,
	input  logic                 frame_stall,
	output cms_pkg::frame_item_t frame
);
	import cms_pkg::*;

	logic        valid_s1;
	byte_item_t  item_s1;
	logic        out_free;
	logic        step;
	logic        emit;
	frame_item_t packed_frame;

	assign out_free   = !frame_valid || !frame_stall;
	assign step       = valid_s1 && (!emit || out_free);
	assign data_stall = valid_s1 && !step;

	cms_packer #(
		.INDEX_BITS(INDEX_BITS)
	) u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (item_s1),
		.emit  (emit),
		.frame (packed_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			item_s1 <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
		end else if (out_free) begin
			frame_valid <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && emit) begin
			frame <= packed_frame;
		end
	end

endmodule

// ===== sim/tb_can_message_segmenter.sv =====
`timescale 1ns / 1ps

module tb_can_message_segmenter;
	import cms_pkg::*;

	localparam int INDEX_BITS = 6;

	typedef struct {
		byte_item_t item;
		bit         drain_first;
	} queued_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	byte_item_t  data = '0;
	logic        frame_valid;
	logic        frame_stall = 1'b0;
	frame_item_t frame;

	queued_byte_t pending_bytes[$];
	frame_item_t  expected_frames[$];
	int           mismatches = 0;

	logic [7:0]            held_bytes[FRAME_BYTES];
	int                    held_count = 0;
	logic [INDEX_BITS-1:0] open_index = '0;
	bit                    at_message_start = 1'b1;

	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int recv_calm = 0;

	can_message_segmenter #(.INDEX_BITS(INDEX_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data(data),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Adds one byte to the open frame and returns 1 when it closes the frame.
	function automatic bit pack_byte(input byte_item_t b, output frame_item_t f);
		logic [7:0] frame_bytes[FRAME_BYTES];
		int         n;
		f = '0;
		for (int i = 0; i < FRAME_BYTES; i++)
			frame_bytes[i] = (i < held_count) ? held_bytes[i] : 8'h00;
		frame_bytes[held_count] = b.data_byte;
		n = held_count + 1;
		if (!b.last_byte && n < FRAME_BYTES) begin
			held_bytes[held_count] = b.data_byte;
			held_count = n;
			return 1'b0;
		end
		f.out_id = b.frame_id;
		if (b.last_byte)
			f.segment_type = at_message_start ? SEG_SINGLE : SEG_END;
		else
			f.segment_type = at_message_start ? SEG_BEGIN : SEG_MIDDLE;
		f.segment_index = at_message_start ? '0 : SEG_IDX_W'(open_index);
		f.length_code = LEN_W'(n + 1);
		f.payload_0 = frame_bytes[0];
		f.payload_1 = frame_bytes[1];
		f.payload_2 = frame_bytes[2];
		f.payload_3 = frame_bytes[3];
		f.payload_4 = frame_bytes[4];
		f.payload_5 = frame_bytes[5];
		f.payload_6 = frame_bytes[6];
		held_count = 0;
		for (int i = 0; i < FRAME_BYTES; i++)
			held_bytes[i] = 8'h00;
		if (b.last_byte) begin
			open_index = '0;
			at_message_start = 1'b1;
		end else begin
			open_index = open_index + 1'b1;
			at_message_start = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int pick_idle(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 10);
		return $urandom_range(15, 50);
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic add_byte(input logic [7:0] value, input bit last, input logic [28:0] id,
			input bit drain);
		queued_byte_t q;
		q.item.data_byte = value;
		q.item.last_byte = last;
		q.item.frame_id = id;
		q.drain_first = drain;
		pending_bytes.push_back(q);
	endtask

	task automatic add_message(input int len, input bit drain);
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom()), i == len - 1, 29'($urandom()), drain && i == 0);
	endtask

	always @(posedge clk) begin : drive
		frame_item_t f;
		bit          ready;
		if (arst_n) begin
			ready = !data_valid || !data_stall;
			if (data_valid && !data_stall) begin
				if (pack_byte(data, f))
					expected_frames.push_back(f);
			end
			if (ready) begin
				if (send_gap > 0) begin
					send_gap--;
					data_valid <= 1'b0;
				end else if (pending_bytes.size() > 0 &&
						!(pending_bytes[0].drain_first && expected_frames.size() > 0)) begin
					data <= pending_bytes[0].item;
					data_valid <= 1'b1;
					pending_bytes.pop_front();
					send_gap = pick_idle(send_calm);
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : receive
		frame_item_t want;
		if (arst_n) begin
			if (frame_valid && !frame_stall) begin
				if (expected_frames.size() == 0) begin
					$display("%0t ns: frame with nothing expected, got %p", $time, frame);
					mismatches++;
				end else begin
					want = expected_frames.pop_front();
					check_field("out_id", want.out_id, frame.out_id);
					check_field("segment_type", want.segment_type, frame.segment_type);
					check_field("segment_index", want.segment_index, frame.segment_index);
					check_field("length_code", want.length_code, frame.length_code);
					check_field("payload_0", want.payload_0, frame.payload_0);
					check_field("payload_1", want.payload_1, frame.payload_1);
					check_field("payload_2", want.payload_2, frame.payload_2);
					check_field("payload_3", want.payload_3, frame.payload_3);
					check_field("payload_4", want.payload_4, frame.payload_4);
					check_field("payload_5", want.payload_5, frame.payload_5);
					check_field("payload_6", want.payload_6, frame.payload_6);
				end
			end
			if (stall_left == 0)
				stall_left = pick_idle(recv_calm);
			if (stall_left > 0) begin
				stall_left--;
				frame_stall <= 1'b1;
			end else begin
				frame_stall <= 1'b0;
			end
		end
	end

	initial begin
		int total;
		int r;
		int len;
		bit long_done;
		for (int i = 0; i < FRAME_BYTES; i++)
			held_bytes[i] = 8'h00;

		add_byte(8'hFF, 1'b1, 29'h1FFFFFFF, 1'b0);
		add_byte(8'h00, 1'b0, 29'h00000000, 1'b0);
		add_byte(8'hFF, 1'b0, 29'h1FFFFFFF, 1'b0);
		add_byte(8'h55, 1'b0, 29'h0AAAAAAA, 1'b0);
		add_byte(8'hAA, 1'b0, 29'h15555555, 1'b0);
		add_byte(8'h01, 1'b0, 29'h00000001, 1'b0);
		add_byte(8'h80, 1'b0, 29'h10000000, 1'b0);
		add_byte(8'h7F, 1'b1, 29'h00000000, 1'b0);
		for (int i = 0; i < 16; i++)
			add_byte(8'(i * 17 + 3), i == 15, (i % 2) ? 29'h1FFFFFFF : 29'h0, 1'b0);

		total = pending_bytes.size();
		long_done = 1'b0;
		add_message(9, 1'b1);
		total += 9;
		while (total < 1300) begin
			r = $urandom_range(0, 99);
			if (!long_done && total > 400) begin
				len = 470 + $urandom_range(0, 6);
				long_done = 1'b1;
			end else if (r < 55) begin
				len = $urandom_range(1, 14);
			end else if (r < 80) begin
				len = $urandom_range(15, 40);
			end else begin
				len = 7 * $urandom_range(1, 6);
			end
			add_message(len, $urandom_range(0, 19) == 0);
			total += len;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() > 0 || data_valid)
			@(posedge clk);
		while (expected_frames.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0)
			$display("[can_message_segmenter] OK");
		else
			$display("[can_message_segmenter] ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[can_message_segmenter] ERROR");
		$finish;
	end

endmodule
